// ----- hw/rtl/toi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toi_pkg
// Shared types, constants and tables of the twist odometry integrator.
// ----------------------------------------------------------------------------
package toi_pkg;

   // field widths and step counts
   localparam int COORD_W      = 32;
   localparam int ANGLE_W      = 16;
   localparam int TRIG_FRAC    = 30;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 34;

   // pi in q30, cordic start value (gain pre-applied) in q30
   localparam logic [31:0]        PI_Q30  = 32'd3373259426;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

   // atan(2^-i), 2^32 per full turn
   localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861
   };

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE, ST_TINIT, ST_TCOR, ST_TSTORE, ST_NMUL, ST_DXS, ST_DXW,
      ST_DYS, ST_DYW, ST_HINIT, ST_HCOR, ST_HSTORE, ST_RMUL, ST_UPD, ST_PUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_in;
      logic       cor_init;
      logic       cor_sel_head;
      logic       cor_step;
      logic [3:0] cor_idx;
      logic       store_turn_trig;
      logic       store_head_trig;
      logic       mul_en;
      logic       mul_rot;
      logic [1:0] mul_idx;
      logic       acc_clr;
      logic       acc_en;
      logic [1:0] acc_idx;
      logic       pass_thru;
      logic       div_start;
      logic       div_sel_y;
      logic       store_dx;
      logic       store_dy;
      logic       pose_upd;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic turn_zero;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/twist_odometry_integrator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twist_odometry_integrator
// Planar odometry: integrates one body twist per item into an x, y, heading pose.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one body twist per item: forward and lateral step in
//   signed q16.16, turn as a 16-bit binary angle (32768 is pi).
//   rsp channel returns the updated pose for every item: x, y in q16.16
//   (saturated) and the heading (wrapping).
//   One item is in work at a time. A nonzero turn takes two 16-step cordic
//   passes, two 34-step divides by the turn on one shared divider, and two
//   rounds of four products on one shared multiplier. A zero turn skips the
//   first cordic pass, the first round of products and the divides.
//   The result sits in an output register; a new item is taken while it waits.
//   If the receiver stalls, the next finished pose waits until the register
//   frees up, and no further item is taken until then.
//   Reset clears the pose to zero and empties the output register.
// ----------------------------------------------------------------------------
module twist_odometry_integrator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // forward_step [31:0], lateral_step [63:32], turn_step [79:64]
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pose_x_out [31:0], pose_y_out [63:32], heading_out [79:64]
   output logic [79:0]      rsp_tdata
);

   toi_pkg::cmd_type    cmd;
   toi_pkg::status_type status;
   logic signed [31:0]  out_x, out_y;
   logic signed [15:0]  out_heading;

   toi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   toi_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_forward  ($signed(req_tdata[31:0])),
      .in_lateral  ($signed(req_tdata[63:32])),
      .in_turn     ($signed(req_tdata[79:64])),
      .status      (status),
      .out_x       (out_x),
      .out_y       (out_y),
      .out_heading (out_heading)
   );

   assign rsp_tdata = {out_heading, out_y, out_x};

endmodule
`default_nettype wire

// ----- hw/rtl/toi_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toi_div
// Restoring divider: rounded |num| * 2^15 / den, signed, |q| clamped to 2^32-1.
// ----------------------------------------------------------------------------
module toi_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [66:0] num,
   input  wire logic [47:0]        den,
   input  wire logic               den_neg,
   output logic                    done,
   output logic signed [33:0]      quot
);

   localparam logic [34:0] LIM = 35'h0FFFFFFFF;

   logic [81:0]        rem_ff, rem_in;
   logic [81:0]        dsh_ff, dsh_in;
   logic [33:0]        q_ff, q_in;
   logic [47:0]        den_ff, den_in;
   logic               ovf_ff, ovf_in;
   logic               neg_ff, neg_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic signed [33:0] quot_ff, quot_in;

   logic [66:0] n_mag;
   logic [81:0] n_ext;
   logic        rnd;
   logic [34:0] q_rnd;
   logic [31:0] mag;

   // operand preparation
   always_comb begin
      n_mag = num[66] ? 67'(-num) : 67'(num);
      n_ext = {4'b0, n_mag[62:0], 15'b0};
   end

   // iteration and final rounding
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      quot_in = quot_ff;
      rnd     = {rem_ff[47:0], 1'b0} >= {1'b0, den_ff};
      q_rnd   = {1'b0, q_ff} + 35'(rnd);
      mag     = (ovf_ff || q_rnd > LIM) ? LIM[31:0] : q_rnd[31:0];
      if (start) begin
         rem_in = n_ext;
         dsh_in = {1'b0, den, 33'b0};
         q_in   = '0;
         den_in = den;
         ovf_in = n_ext >= {den, 34'b0};
         neg_in = num[66] ^ den_neg;
         cnt_in = 6'(toi_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[32:0], 1'b1};
         end else begin
            q_in   = {q_ff[32:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 6'd1;
         fin_in = cnt_ff == 6'd1;
      end
      if (fin_ff) begin
         done_in = 1'b1;
         quot_in = neg_ff ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
      ovf_ff  <= ovf_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (cnt_ff == '0 && !fin_ff)) else $error("divider restarted while busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'(toi_pkg::DIV_STEPS)) else $error("divider count out of range");
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> done_ff) else $error("divider result not flagged");

endmodule
`default_nettype wire

// ----- hw/rtl/toi_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toi_datapath
// Pose state, shared cordic, shared multiplier with accumulators, divider.
// ----------------------------------------------------------------------------
module toi_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire toi_pkg::cmd_type   cmd,
   input  wire logic signed [31:0] in_forward,
   input  wire logic signed [31:0] in_lateral,
   input  wire logic signed [15:0] in_turn,
   output toi_pkg::status_type     status,
   output logic signed [31:0]      out_x,
   output logic signed [31:0]      out_y,
   output logic signed [15:0]      out_heading
);

   localparam logic signed [33:0] QUARTER = 34'sd1073741824;
   localparam logic signed [33:0] HALF    = 34'sd2147483648;
   localparam logic signed [32:0] ONE     = 33'sd1073741824;
   localparam logic signed [66:0] RND     = 67'sd536870912;
   localparam logic signed [37:0] PMAX    = 38'sd2147483647;
   localparam logic signed [37:0] PMIN    = -38'sd2147483648;

   // clamp a cordic output to [-1, 1] in q30
   function automatic logic signed [31:0] clamp_trig(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > QUARTER)       r = 32'sd1073741824;
      else if (v < -QUARTER) r = -32'sd1073741824;
      else                   r = 32'(v);
      return r;
   endfunction

   // saturate a position sum
   function automatic logic signed [31:0] sat_pos(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > PMAX)      r = 32'sd2147483647;
      else if (v < PMIN) r = -32'sd2147483648;
      else               r = 32'(v);
      return r;
   endfunction

   logic signed [31:0] vx_ff, vy_ff;
   logic signed [15:0] turn_ff;
   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic signed [15:0] heading_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic               flip_ff;
   logic signed [31:0] ct_ff, st_ff, ch_ff, sh_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic signed [66:0] prod_ff, acc_a_ff, acc_b_ff;
   logic [47:0]        den_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic signed [15:0] oh_ff;

   logic signed [15:0] ang;
   logic signed [33:0] z0, xs, ys, atan_v, fx, fy;
   logic signed [33:0] a_op;
   logic signed [32:0] b_op;
   logic signed [66:0] prod_in;
   logic signed [16:0] t_ext;
   logic [16:0]        t_mag;
   logic [48:0]        den_full;
   logic signed [66:0] rnd_a, rnd_b;
   logic signed [36:0] rx, ry;
   logic               div_done;
   logic signed [33:0] div_q;

   // cordic setup and step terms
   always_comb begin
      ang    = cmd.cor_sel_head ? heading_ff : turn_ff;
      z0     = {{2{ang[15]}}, ang, 16'b0};
      xs     = cx_ff >>> cmd.cor_idx;
      ys     = cy_ff >>> cmd.cor_idx;
      atan_v = 34'(toi_pkg::ATAN_TAB[cmd.cor_idx]);
      fx     = flip_ff ? -cx_ff : cx_ff;
      fy     = flip_ff ? -cy_ff : cy_ff;
   end

   // cordic registers
   always_ff @(posedge clock) begin
      if (cmd.cor_init) begin
         cx_ff <= toi_pkg::CORDIC_X0;
         cy_ff <= '0;
         if (z0 > QUARTER) begin
            cz_ff   <= z0 - HALF;
            flip_ff <= 1'b1;
         end else if (z0 < -QUARTER) begin
            cz_ff   <= z0 + HALF;
            flip_ff <= 1'b1;
         end else begin
            cz_ff   <= z0;
            flip_ff <= 1'b0;
         end
      end else if (cmd.cor_step) begin
         if (cz_ff >= 0) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - atan_v;
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + atan_v;
         end
      end
      if (cmd.store_turn_trig) begin
         ct_ff <= clamp_trig(fx);
         st_ff <= clamp_trig(fy);
      end
      if (cmd.store_head_trig) begin
         ch_ff <= clamp_trig(fx);
         sh_ff <= clamp_trig(fy);
      end
   end

   // multiplier operand select
   always_comb begin
      a_op = '0;
      b_op = '0;
      if (cmd.mul_rot) begin
         unique case (cmd.mul_idx)
            2'd0: begin a_op = dx_ff; b_op = 33'(ch_ff);  end
            2'd1: begin a_op = dy_ff; b_op = -33'(sh_ff); end
            2'd2: begin a_op = dx_ff; b_op = 33'(sh_ff);  end
            default: begin a_op = dy_ff; b_op = 33'(ch_ff); end
         endcase
      end else begin
         unique case (cmd.mul_idx)
            2'd0: begin a_op = 34'(vx_ff); b_op = 33'(st_ff);       end
            2'd1: begin a_op = 34'(vy_ff); b_op = 33'(ct_ff) - ONE; end
            2'd2: begin a_op = 34'(vy_ff); b_op = 33'(st_ff);       end
            default: begin a_op = 34'(vx_ff); b_op = ONE - 33'(ct_ff); end
         endcase
      end
      prod_in = a_op * b_op;
   end

   // product and accumulators
   always_ff @(posedge clock) begin
      if (cmd.mul_en)
         prod_ff <= prod_in;
      if (cmd.acc_clr) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else if (cmd.acc_en) begin
         if (cmd.acc_idx[1]) acc_b_ff <= acc_b_ff + prod_ff;
         else                acc_a_ff <= acc_a_ff + prod_ff;
      end
   end

   // divisor |turn| * pi
   always_comb begin
      t_ext    = {turn_ff[15], turn_ff};
      t_mag    = t_ext[16] ? 17'(-t_ext) : 17'(t_ext);
      den_full = {32'b0, t_mag} * {17'b0, toi_pkg::PI_Q30};
   end

   always_ff @(posedge clock) begin
      den_ff <= den_full[47:0];
   end

   toi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num     (cmd.div_sel_y ? acc_b_ff : acc_a_ff),
      .den     (den_ff),
      .den_neg (turn_ff[15]),
      .done    (div_done),
      .quot    (div_q)
   );

   // input item and body increment
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         vx_ff   <= in_forward;
         vy_ff   <= in_lateral;
         turn_ff <= in_turn;
      end
      if (cmd.pass_thru) begin
         dx_ff <= 34'(vx_ff);
         dy_ff <= 34'(vy_ff);
      end
      if (cmd.store_dx) dx_ff <= div_q;
      if (cmd.store_dy) dy_ff <= div_q;
   end

   // rotated increment, rounded
   always_comb begin
      rnd_a = (acc_a_ff + RND) >>> 30;
      rnd_b = (acc_b_ff + RND) >>> 30;
      rx    = 37'(rnd_a);
      ry    = 37'(rnd_b);
   end

   // pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         heading_ff <= '0;
      end else if (cmd.pose_upd) begin
         pose_x_ff  <= sat_pos(38'(pose_x_ff) + 38'(rx));
         pose_y_ff  <= sat_pos(38'(pose_y_ff) + 38'(ry));
         heading_ff <= heading_ff + turn_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ox_ff <= pose_x_ff;
         oy_ff <= pose_y_ff;
         oh_ff <= heading_ff;
      end
   end

   assign status.turn_zero = turn_ff == '0;
   assign status.div_done  = div_done;
   assign out_x       = ox_ff;
   assign out_y       = oy_ff;
   assign out_heading = oh_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/toi_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toi_ctrl
// Sequencer: cordic, multiply, divide, rotate and update steps of one item.
// ----------------------------------------------------------------------------
module toi_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire toi_pkg::status_type  status,
   output toi_pkg::cmd_type          cmd
);

   localparam logic [4:0] LAST_STEP = 5'(toi_pkg::CORDIC_STEPS - 1);

   toi_pkg::state_type state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               valid_ff, valid_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= toi_pkg::ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff && !rsp_tready;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         toi_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = toi_pkg::ST_TINIT;
            end
         end
         toi_pkg::ST_TINIT: begin
            cnt_in = '0;
            if (status.turn_zero) begin
               cmd.pass_thru = 1'b1;
               state_in      = toi_pkg::ST_HINIT;
            end else begin
               cmd.cor_init = 1'b1;
               state_in     = toi_pkg::ST_TCOR;
            end
         end
         toi_pkg::ST_TCOR: begin
            cmd.cor_step = 1'b1;
            cmd.cor_idx  = cnt_ff[3:0];
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = toi_pkg::ST_TSTORE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         toi_pkg::ST_TSTORE: begin
            cmd.store_turn_trig = 1'b1;
            state_in            = toi_pkg::ST_NMUL;
         end
         toi_pkg::ST_NMUL, toi_pkg::ST_RMUL: begin
            cmd.mul_rot = state_ff == toi_pkg::ST_RMUL;
            cmd.mul_en  = cnt_ff < 5'd4;
            cmd.mul_idx = cnt_ff[1:0];
            cmd.acc_clr = cnt_ff == '0;
            cmd.acc_en  = cnt_ff != '0;
            cmd.acc_idx = 2'(cnt_ff - 5'd1);
            if (cnt_ff == 5'd4) begin
               cnt_in   = '0;
               state_in = (state_ff == toi_pkg::ST_RMUL) ? toi_pkg::ST_UPD
                                                         : toi_pkg::ST_DXS;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         toi_pkg::ST_DXS: begin
            cmd.div_start = 1'b1;
            state_in      = toi_pkg::ST_DXW;
         end
         toi_pkg::ST_DXW: begin
            if (status.div_done) begin
               cmd.store_dx = 1'b1;
               state_in     = toi_pkg::ST_DYS;
            end
         end
         toi_pkg::ST_DYS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in      = toi_pkg::ST_DYW;
         end
         toi_pkg::ST_DYW: begin
            cmd.div_sel_y = 1'b1;
            if (status.div_done) begin
               cmd.store_dy = 1'b1;
               state_in     = toi_pkg::ST_HINIT;
            end
         end
         toi_pkg::ST_HINIT: begin
            cmd.cor_init     = 1'b1;
            cmd.cor_sel_head = 1'b1;
            cnt_in           = '0;
            state_in         = toi_pkg::ST_HCOR;
         end
         toi_pkg::ST_HCOR: begin
            cmd.cor_step = 1'b1;
            cmd.cor_idx  = cnt_ff[3:0];
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = toi_pkg::ST_HSTORE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         toi_pkg::ST_HSTORE: begin
            cmd.store_head_trig = 1'b1;
            state_in            = toi_pkg::ST_RMUL;
         end
         toi_pkg::ST_UPD: begin
            cmd.pose_upd = 1'b1;
            state_in     = toi_pkg::ST_PUSH;
         end
         toi_pkg::ST_PUSH: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = toi_pkg::ST_IDLE;
            end
         end
         default: state_in = toi_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = valid_ff;

   // checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second item taken early");
   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!valid_ff || rsp_tready)) else $error("output overwritten");
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == toi_pkg::ST_DXW || state_ff == toi_pkg::ST_DYW))
      else $error("divider result out of sequence");

endmodule
`default_nettype wire
